// File: design/mfsp_pkg.sv
// Shared types and constants for the motor feedback / speed PID core.
// No dependencies; used by mfsp_ctrl, mfsp_dp and the top level.
`default_nettype none
package mfsp_pkg;

	localparam int COUNTS_PER_TURN = 8192;
	localparam int POS_W           = 13;
	localparam int HALF_TURN       = COUNTS_PER_TURN / 2;
	localparam int IDX_W           = 3;
	localparam int DRIVE_LIMIT     = 16384;
	localparam int ANGLE_SCALE     = 360;
	localparam int DPS_SCALE       = 6;
	localparam int ADDR_W          = 5;

	localparam logic [23:0] PROP_GAIN_RST  = 24'd19661;
	localparam logic [23:0] INT_GAIN_RST   = 24'd0;
	localparam logic [23:0] DERIV_GAIN_RST = 24'd3277;
	localparam logic [15:0] STEP_TIME_RST  = 16'd66;
	localparam logic [15:0] INV_GEAR_RST   = 16'd3449;
	localparam logic        UNITS_RST      = 1'b1;
	localparam logic [10:0] BASE_ID_RST    = 11'd513;

	typedef enum logic [2:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INT_GAIN    = 3'd1,
		REG_DERIV_GAIN  = 3'd2,
		REG_STEP_TIME   = 3'd3,
		REG_INV_GEAR    = 3'd4,
		REG_SPEED_UNITS = 3'd5,
		REG_BASE_ID     = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_MUL4,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [23:0] prop_gain;
		logic [23:0] integral_gain;
		logic [23:0] deriv_gain;
		logic [15:0] step_time;
		logic [15:0] inverse_gear;
		logic        speed_units;
		logic [10:0] base_id;
	} cfg_t;

	typedef struct packed {
		state_t phase;
		logic   capture;
		logic   out_load;
	} cmd_t;

	typedef struct packed {
		logic hit;
	} sts_t;

endpackage
`default_nettype wire

// File: design/mfsp_ctrl.sv
// Sequencer for the motor feedback / speed PID core.
// Depends on mfsp_pkg; drives the datapath mfsp_dp through cmd_t / sts_t.
`default_nettype none
module mfsp_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire mfsp_pkg::sts_t sts,
	output mfsp_pkg::cmd_t     cmd
);

	mfsp_pkg::state_t state_q, state_nx;
	logic out_free;

	assign out_free = !out_valid || !out_stall;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			mfsp_pkg::ST_IDLE:   if (in_valid) state_nx = mfsp_pkg::ST_DECODE;
			mfsp_pkg::ST_DECODE: state_nx = sts.hit ? mfsp_pkg::ST_MUL1 : mfsp_pkg::ST_FINISH;
			mfsp_pkg::ST_MUL1:   state_nx = mfsp_pkg::ST_MUL2;
			mfsp_pkg::ST_MUL2:   state_nx = mfsp_pkg::ST_MUL3;
			mfsp_pkg::ST_MUL3:   state_nx = mfsp_pkg::ST_MUL4;
			mfsp_pkg::ST_MUL4:   state_nx = mfsp_pkg::ST_FINISH;
			mfsp_pkg::ST_FINISH: if (out_free) state_nx = mfsp_pkg::ST_IDLE;
			default:             state_nx = mfsp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall     = (state_q != mfsp_pkg::ST_IDLE);
		cmd.phase    = state_q;
		cmd.capture  = (state_q == mfsp_pkg::ST_IDLE) && in_valid;
		cmd.out_load = (state_q == mfsp_pkg::ST_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mfsp_pkg::ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	a_capture_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == mfsp_pkg::ST_DECODE)
		else $error("accepted transaction did not enter decode");
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid && out_stall))
		else $error("result overwrote a stalled transaction");
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("loaded result not presented");

endmodule
`default_nettype wire

// File: design/mfsp_dp.sv
// Datapath: per-motor state, shared signed multiplier, turn tracking and PID sums.
// Depends on mfsp_pkg; sequenced by mfsp_ctrl.
`default_nettype none
module mfsp_dp #(
	parameter int MOTOR_COUNT = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mfsp_pkg::cmd_t      cmd,
	output mfsp_pkg::sts_t           sts,
	input  wire mfsp_pkg::cfg_t      cfg,
	input  wire logic                mode,
	input  wire logic [10:0]         frame_id,
	input  wire logic [12:0]         position_raw,
	input  wire logic signed [15:0]  speed_raw,
	input  wire logic signed [15:0]  current_raw,
	input  wire logic [1:0]          motor_select,
	input  wire logic signed [23:0]  target_speed,
	output logic                     accepted,
	output logic [1:0]               motor_id,
	output logic signed [31:0]       total_count,
	output logic signed [31:0]       angle_degrees,
	output logic signed [23:0]       shaft_speed,
	output logic signed [15:0]       current_echo,
	output logic signed [15:0]       drive_command
);

	localparam int MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

	// per-motor state
	logic [12:0]        last_pos_q [MOTOR_COUNT];
	logic               seen_q     [MOTOR_COUNT];
	logic signed [15:0] turns_q    [MOTOR_COUNT];
	logic signed [23:0] meas_q     [MOTOR_COUNT];
	logic signed [24:0] err_q      [MOTOR_COUNT];
	logic signed [25:0] chg_q      [MOTOR_COUNT];
	logic signed [15:0] drv_q      [MOTOR_COUNT];

	// captured transaction
	logic               mode_q;
	logic [10:0]        fid_q;
	logic [12:0]        pos_q;
	logic signed [15:0] spd_q;
	logic signed [15:0] cur_q;
	logic [1:0]         sel_q;
	logic signed [23:0] tgt_q;

	// working registers
	logic                     hit_q;
	logic [mfsp_pkg::IDX_W-1:0] idx_q;
	logic signed [15:0]       tc_q;
	logic signed [24:0]       e_q;
	logic signed [25:0]       de_q;
	logic signed [25:0]       cb_q;
	logic signed [26:0]       d2e_q;
	logic signed [23:0]       ms_q;
	logic signed [15:0]       acc_q;
	logic [23:0]              kidt_q;
	logic signed [57:0]       prod_q;
	logic signed [53:0]       sum_q;
	logic signed [34:0]       angw_q;
	logic signed [31:0]       ang_q;
	logic signed [35:0]       spdw_q;
	logic signed [23:0]       spdo_q;

	// decode
	logic [11:0]               id_diff;
	logic                      fb_hit, ct_hit, dec_hit;
	logic [mfsp_pkg::IDX_W-1:0] dec_idx;
	logic [MIDX_W-1:0]         ai, wi;
	logic signed [13:0]        pos_diff;
	logic signed [15:0]        tc_nx;
	logic signed [24:0]        e_nx;
	logic signed [25:0]        de_nx;

	always_comb begin
		id_diff  = {1'b0, fid_q} - {1'b0, cfg.base_id};
		fb_hit   = !id_diff[11] && (id_diff[10:0] < 11'(MOTOR_COUNT));
		ct_hit   = ({2'b00, sel_q} < 4'(MOTOR_COUNT));
		dec_hit  = mode_q ? ct_hit : fb_hit;
		dec_idx  = mode_q ? {1'b0, sel_q} : id_diff[mfsp_pkg::IDX_W-1:0];
		ai       = dec_idx[MIDX_W-1:0];
		wi       = idx_q[MIDX_W-1:0];
		pos_diff = $signed({1'b0, pos_q}) - $signed({1'b0, last_pos_q[ai]});
		if (!seen_q[ai])
			tc_nx = '0;
		else if (pos_diff > $signed(14'(mfsp_pkg::HALF_TURN)))
			tc_nx = turns_q[ai] - 16'sd1;
		else if (pos_diff < -$signed(14'(mfsp_pkg::HALF_TURN)))
			tc_nx = turns_q[ai] + 16'sd1;
		else
			tc_nx = turns_q[ai];
		e_nx  = $signed({tgt_q[23], tgt_q}) - $signed({meas_q[ai][23], meas_q[ai]});
		de_nx = $signed({e_nx[24], e_nx}) - $signed({err_q[ai][24], err_q[ai]});
		sts.hit = dec_hit;
	end

	// shared multiplier
	logic signed [29:0] mul_a;
	logic signed [27:0] mul_b;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.phase)
			mfsp_pkg::ST_DECODE: begin
				mul_a = $signed({6'b0, cfg.integral_gain});
				mul_b = $signed({12'b0, cfg.step_time});
			end
			mfsp_pkg::ST_MUL1: begin
				if (mode_q) begin
					mul_a = $signed({6'b0, cfg.prop_gain});
					mul_b = {{2{de_q[25]}}, de_q};
				end else begin
					mul_a = {tc_q[15], tc_q, pos_q};
					mul_b = $signed({12'b0, cfg.inverse_gear});
				end
			end
			mfsp_pkg::ST_MUL2: begin
				if (mode_q) begin
					mul_a = $signed({6'b0, kidt_q});
					mul_b = {{3{e_q[24]}}, e_q};
				end else begin
					mul_a = {{14{spd_q[15]}}, spd_q};
					mul_b = $signed({12'b0, cfg.inverse_gear});
				end
			end
			mfsp_pkg::ST_MUL3: begin
				if (mode_q) begin
					mul_a = $signed({6'b0, cfg.deriv_gain});
					mul_b = {d2e_q[26], d2e_q};
				end
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// constant scalings and saturation
	logic signed [55:0] ang_full;
	logic signed [35:0] spd_ext;
	logic signed [27:0] spd_sh;
	logic signed [29:0] du;
	logic signed [30:0] acc_sum;
	logic signed [15:0] acc_nx;

	always_comb begin
		ang_full = $signed({{10{prod_q[45]}}, prod_q[45:0]}) * 56'sd360;
		spd_ext  = $signed({{3{prod_q[32]}}, prod_q[32:0]});
		spd_sh   = spdw_q[35:8];
		du       = sum_q[53:24];
		acc_sum  = $signed({{15{acc_q[15]}}, acc_q}) + $signed({du[29], du});
		if (acc_sum > $signed(31'(mfsp_pkg::DRIVE_LIMIT)))
			acc_nx = 16'(mfsp_pkg::DRIVE_LIMIT);
		else if (acc_sum < -$signed(31'(mfsp_pkg::DRIVE_LIMIT)))
			acc_nx = -16'(mfsp_pkg::DRIVE_LIMIT);
		else
			acc_nx = acc_sum[15:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			fid_q  <= frame_id;
			pos_q  <= position_raw;
			spd_q  <= speed_raw;
			cur_q  <= current_raw;
			sel_q  <= motor_select;
			tgt_q  <= target_speed;
		end
		prod_q <= mul_a * mul_b;
		case (cmd.phase)
			mfsp_pkg::ST_DECODE: begin
				hit_q <= dec_hit;
				idx_q <= dec_idx;
				tc_q  <= tc_nx;
				e_q   <= e_nx;
				de_q  <= de_nx;
				cb_q  <= chg_q[ai];
				ms_q  <= meas_q[ai];
				acc_q <= drv_q[ai];
			end
			mfsp_pkg::ST_MUL1: begin
				kidt_q <= prod_q[39:16];
				d2e_q  <= $signed({de_q[25], de_q}) - $signed({cb_q[25], cb_q});
			end
			mfsp_pkg::ST_MUL2: begin
				// round half up folded into the first term
				sum_q  <= prod_q[53:0] + 54'sd8388608;
				angw_q <= ang_full[55:21];
			end
			mfsp_pkg::ST_MUL3: begin
				sum_q <= sum_q + prod_q[53:0];
				if (angw_q > 35'sh07FFFFFFF)
					ang_q <= 32'sh7FFFFFFF;
				else if (angw_q < -35'sh080000000)
					ang_q <= 32'sh80000000;
				else
					ang_q <= angw_q[31:0];
				spdw_q <= cfg.speed_units ? spd_ext * 36'sd6 : spd_ext;
			end
			mfsp_pkg::ST_MUL4: begin
				sum_q <= sum_q + prod_q[53:0];
				if (spd_sh > 28'sh07FFFFF)
					spdo_q <= 24'sh7FFFFF;
				else if (spd_sh < -28'sh0800000)
					spdo_q <= 24'sh800000;
				else
					spdo_q <= spd_sh[23:0];
			end
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			accepted      <= hit_q;
			motor_id      <= hit_q ? idx_q[1:0] : 2'b00;
			total_count   <= '0;
			angle_degrees <= '0;
			shaft_speed   <= '0;
			current_echo  <= '0;
			drive_command <= '0;
			if (hit_q && mode_q) begin
				shaft_speed   <= ms_q;
				drive_command <= acc_nx;
			end else if (hit_q) begin
				total_count   <= {{3{tc_q[15]}}, tc_q, pos_q};
				angle_degrees <= ang_q;
				shaft_speed   <= spdo_q;
				current_echo  <= cur_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				last_pos_q[i] <= '0;
				seen_q[i]     <= 1'b0;
				turns_q[i]    <= '0;
				meas_q[i]     <= '0;
				err_q[i]      <= '0;
				chg_q[i]      <= '0;
				drv_q[i]      <= '0;
			end
		end else if (cmd.out_load && hit_q) begin
			if (mode_q) begin
				drv_q[wi] <= acc_nx;
				err_q[wi] <= e_q;
				chg_q[wi] <= de_q;
			end else begin
				last_pos_q[wi] <= pos_q;
				seen_q[wi]     <= 1'b1;
				turns_q[wi]    <= tc_q;
				meas_q[wi]     <= spdo_q;
			end
		end
	end

	a_drive_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && hit_q && mode_q) |->
		(acc_nx >= -16'sd16384 && acc_nx <= 16'sd16384))
		else $error("drive accumulator out of range");

endmodule
`default_nettype wire

// File: design/motor_feedback_speed_pid_core.sv
// Motor feedback tracking and incremental speed PID for up to MOTOR_COUNT motors.
// Depends on mfsp_pkg, mfsp_ctrl and mfsp_dp; holds the APB register file.
//
// One transaction at a time: a matched feedback frame or control step passes
// through decode, the multiply states MUL1 to MUL4 around the single shared 30x28
// multiplier and finish before its result is presented; an unmatched frame id or
// out-of-range motor passes through decode and finish only. A new transaction is
// not accepted until the last one has left finish. The result sits in an
// output register; the next transaction is accepted in the cycle after that
// register is loaded, even while the result is stalled, and then waits in finish
// until the stalled result is taken. Registers at byte address 4*i: prop_gain,
// integral_gain, deriv_gain, step_time, inverse_gear, speed_units, base_id.
// Write only while idle.
`default_nettype none
module motor_feedback_speed_pid_core #(
	parameter int MOTOR_COUNT = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          mode,
	input  wire logic [10:0]                   frame_id,
	input  wire logic [12:0]                   position_raw,
	input  wire logic signed [15:0]            speed_raw,
	input  wire logic signed [15:0]            current_raw,
	input  wire logic [1:0]                    motor_select,
	input  wire logic signed [23:0]            target_speed,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               accepted,
	output logic [1:0]                         motor_id,
	output logic signed [31:0]                 total_count,
	output logic signed [31:0]                 angle_degrees,
	output logic signed [23:0]                 shaft_speed,
	output logic signed [15:0]                 current_echo,
	output logic signed [15:0]                 drive_command,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mfsp_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	mfsp_pkg::cfg_t cfg_q;
	mfsp_pkg::cmd_t cmd;
	mfsp_pkg::sts_t sts;
	mfsp_pkg::reg_idx_t ridx;
	logic wr_en;

	assign pready = 1'b1;
	assign ridx   = mfsp_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain     <= mfsp_pkg::PROP_GAIN_RST;
			cfg_q.integral_gain <= mfsp_pkg::INT_GAIN_RST;
			cfg_q.deriv_gain    <= mfsp_pkg::DERIV_GAIN_RST;
			cfg_q.step_time     <= mfsp_pkg::STEP_TIME_RST;
			cfg_q.inverse_gear  <= mfsp_pkg::INV_GEAR_RST;
			cfg_q.speed_units   <= mfsp_pkg::UNITS_RST;
			cfg_q.base_id       <= mfsp_pkg::BASE_ID_RST;
		end else if (wr_en) begin
			unique case (ridx)
				mfsp_pkg::REG_PROP_GAIN:   cfg_q.prop_gain     <= pwdata[23:0];
				mfsp_pkg::REG_INT_GAIN:    cfg_q.integral_gain <= pwdata[23:0];
				mfsp_pkg::REG_DERIV_GAIN:  cfg_q.deriv_gain    <= pwdata[23:0];
				mfsp_pkg::REG_STEP_TIME:   cfg_q.step_time     <= pwdata[15:0];
				mfsp_pkg::REG_INV_GEAR:    cfg_q.inverse_gear  <= pwdata[15:0];
				mfsp_pkg::REG_SPEED_UNITS: cfg_q.speed_units   <= pwdata[0];
				mfsp_pkg::REG_BASE_ID:     cfg_q.base_id       <= pwdata[10:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			mfsp_pkg::REG_PROP_GAIN:   prdata = {8'b0, cfg_q.prop_gain};
			mfsp_pkg::REG_INT_GAIN:    prdata = {8'b0, cfg_q.integral_gain};
			mfsp_pkg::REG_DERIV_GAIN:  prdata = {8'b0, cfg_q.deriv_gain};
			mfsp_pkg::REG_STEP_TIME:   prdata = {16'b0, cfg_q.step_time};
			mfsp_pkg::REG_INV_GEAR:    prdata = {16'b0, cfg_q.inverse_gear};
			mfsp_pkg::REG_SPEED_UNITS: prdata = {31'b0, cfg_q.speed_units};
			mfsp_pkg::REG_BASE_ID:     prdata = {21'b0, cfg_q.base_id};
			default:                   prdata = '0;
		endcase
	end

	mfsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mfsp_dp #(
		.MOTOR_COUNT (MOTOR_COUNT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg           (cfg_q),
		.mode          (mode),
		.frame_id      (frame_id),
		.position_raw  (position_raw),
		.speed_raw     (speed_raw),
		.current_raw   (current_raw),
		.motor_select  (motor_select),
		.target_speed  (target_speed),
		.accepted      (accepted),
		.motor_id      (motor_id),
		.total_count   (total_count),
		.angle_degrees (angle_degrees),
		.shaft_speed   (shaft_speed),
		.current_echo  (current_echo),
		.drive_command (drive_command)
	);

endmodule
`default_nettype wire
